// ===== sv/lkfe_pkg.sv =====
// Shared types and constants for the ladder keypad frequency entry block.
// Holds the threshold ladder, key classes, codes and the result record.
// No dependencies.
package lkfe_pkg;

    localparam int SAMPLE_W = 10;
    localparam int FREQ_W   = 14;
    localparam int CFG_W    = 14;
    localparam int CFG_AW   = 2;
    localparam int LADDER_N = 15;

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_NO_KEY_LEVEL = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_FREQ_MIN     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FREQ_MAX     = 2'd2;

    localparam logic [SAMPLE_W-1:0] NO_KEY_LEVEL_RST = 10'd50;
    localparam logic [FREQ_W-1:0]   FREQ_MIN_RST     = 14'd10;
    localparam logic [FREQ_W-1:0]   FREQ_MAX_RST     = 14'd5000;

    // Key and digit codes
    localparam logic [3:0] KEY_STAR   = 4'd10;
    localparam logic [3:0] KEY_HASH   = 4'd11;
    localparam logic [3:0] BLANK_CODE = 4'd15;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [3:0] DIGIT_ONE  = 4'd1;
    localparam logic [3:0] DIGIT_ZERO = 4'd0;

    // Waveform modes
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_RAMP   = 2'd1;
    localparam logic [1:0] MODE_SQUARE = 2'd2;
    localparam logic [1:0] MODE_DTMF   = 2'd3;

    localparam logic [FREQ_W-1:0] FREQ_RST      = 14'd10;
    localparam logic [FREQ_W-1:0] ENTRY_SAT_MAX = 14'd9999;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DIGIT,
        CLS_MODE,
        CLS_STAR,
        CLS_HASH
    } t_key_class;

    // Decoded key handed from the classifier to the entry logic
    typedef struct packed {
        t_key_class cls;
        logic [3:0] code;
    } t_key_evt;

    // One result item
    typedef struct packed {
        logic [3:0]        last_key;
        logic [1:0]        wave_mode;
        logic [FREQ_W-1:0] stored_freq;
        logic [FREQ_W-1:0] entry_value;
        logic [1:0]        entry_place;
        logic              commit_error;
    } t_result;

    // Descending ladder: first threshold the sample exceeds wins
    localparam logic [SAMPLE_W-1:0] LADDER_LIM [0:LADDER_N-1] = '{
        10'd600, 10'd400, 10'd280, 10'd240, 10'd200, 10'd170, 10'd145, 10'd131,
        10'd120, 10'd108, 10'd97,  10'd90,  10'd85,  10'd77,  10'd73
    };

    localparam t_key_class LADDER_CLS [0:LADDER_N-1] = '{
        CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_MODE,
        CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_MODE,
        CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_MODE,
        CLS_STAR,  CLS_DIGIT, CLS_HASH
    };

    localparam logic [3:0] LADDER_CODE [0:LADDER_N-1] = '{
        4'd7, 4'd8, 4'd9, {2'b00, MODE_SINE},
        4'd4, 4'd5, 4'd6, {2'b00, MODE_RAMP},
        4'd1, 4'd2, 4'd3, {2'b00, MODE_SQUARE},
        KEY_STAR, 4'd0, KEY_HASH
    };

endpackage

// ===== sv/ladder_keypad_frequency_entry.sv =====
// Top level of the ladder keypad frequency entry block.
// Uses lkfe_pkg, lkfe_classify and lkfe_entry.
//
// One keypad ADC sample per item in, one result item out. The block takes
// one item per clock while the result register is free or draining: a
// sample sits in an input register, passes through one combinational pass
// (ladder compare, buffer update, decimal parse of at most ENTRY_DIGITS
// places, limit test) and lands in the result register. While a result
// waits for the sink the input register still takes one item, then
// s_axis_tready stays low until the result drains.
// Configuration registers must only be written while no item is in flight.
module ladder_keypad_frequency_entry import lkfe_pkg::*; #(
    parameter int ENTRY_DIGITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port
    input  logic              i_cfg_wr_en,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Sample stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // [9:0] adc_sample
    // Result stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [3:0] last_key, [5:4] wave_mode, [19:6] stored_freq,
    // [33:20] entry_value, [35:34] entry_place, [36] commit_error
    output logic [39:0]       m_axis_tdata
);

    logic [SAMPLE_W-1:0] r_no_key_level;
    logic [FREQ_W-1:0]   r_freq_min;
    logic [FREQ_W-1:0]   r_freq_max;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_out;
    logic                w_fire;
    t_key_evt            w_evt;
    t_result             w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_key_level <= NO_KEY_LEVEL_RST;
            r_freq_min     <= FREQ_MIN_RST;
            r_freq_max     <= FREQ_MAX_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_NO_KEY_LEVEL: r_no_key_level <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_FREQ_MIN:     r_freq_min     <= i_cfg_wdata[FREQ_W-1:0];
                CFG_FREQ_MAX:     r_freq_max     <= i_cfg_wdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Process the held item when the result register is free or draining
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    lkfe_classify u_classify (
        .i_sample       (r_sample),
        .i_no_key_level (r_no_key_level),
        .o_evt          (w_evt)
    );

    lkfe_entry #(
        .ENTRY_DIGITS (ENTRY_DIGITS)
    ) u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_evt      (w_evt),
        .i_freq_min (r_freq_min),
        .i_freq_max (r_freq_max),
        .o_res      (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.commit_error, r_out.entry_place,
                            r_out.entry_value, r_out.stored_freq,
                            r_out.wave_mode, r_out.last_key};

endmodule

// ===== sv/lkfe_classify.sv =====
// Key classifier: maps one ladder sample to a key class and code.
// Depends on lkfe_pkg for the threshold ladder.
module lkfe_classify import lkfe_pkg::*; (
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_no_key_level,
    output t_key_evt            o_evt
);

    // Priority search: walk the ladder bottom up so the highest step wins
    always_comb begin
        o_evt.cls  = CLS_MODE;
        o_evt.code = {2'b00, MODE_DTMF};
        for (int i = LADDER_N - 1; i >= 0; i--) begin
            if (i_sample > LADDER_LIM[i]) begin
                o_evt.cls  = LADDER_CLS[i];
                o_evt.code = LADDER_CODE[i];
            end
        end
        if (i_sample < i_no_key_level) begin
            o_evt.cls  = CLS_NONE;
            o_evt.code = DIGIT_ZERO;
        end
    end

endmodule

// ===== sv/lkfe_entry.sv =====
// Entry state: digit buffer, write place, last key, mode and stored frequency.
// Applies one decoded key per fire and forms the result. Depends on lkfe_pkg.
module lkfe_entry import lkfe_pkg::*; #(
    parameter int ENTRY_DIGITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_key_evt          i_evt,
    input  logic [FREQ_W-1:0] i_freq_min,
    input  logic [FREQ_W-1:0] i_freq_max,
    output t_result           o_res
);

    localparam int PLACE_W = $clog2(ENTRY_DIGITS);
    localparam int VAL_W   = $clog2(10 ** ENTRY_DIGITS);
    localparam int CMP_W   = (VAL_W > FREQ_W) ? VAL_W : FREQ_W;
    localparam logic [PLACE_W-1:0] LAST_PLACE = PLACE_W'(ENTRY_DIGITS - 1);

    logic [3:0]         r_buf [ENTRY_DIGITS];
    logic [3:0]         n_buf [ENTRY_DIGITS];
    logic [3:0]         w_default_buf [ENTRY_DIGITS];
    logic [PLACE_W-1:0] r_place, n_place;
    logic [3:0]         r_key, n_key;
    logic [1:0]         r_mode, n_mode;
    logic [FREQ_W-1:0]  r_freq, n_freq;
    logic [VAL_W-1:0]   r_value, n_value;
    logic               w_err;
    logic               w_stop;
    logic [CMP_W-1:0]   w_val_ext, w_new_ext, w_min_ext, w_max_ext;
    logic [PLACE_W+1:0] w_place_ext;

    // Buffer contents after reset or star: "10" then blanks
    always_comb begin
        for (int i = 0; i < ENTRY_DIGITS; i++) begin
            if (i == 0) begin
                w_default_buf[i] = DIGIT_ONE;
            end else if (i == 1) begin
                w_default_buf[i] = DIGIT_ZERO;
            end else begin
                w_default_buf[i] = BLANK_CODE;
            end
        end
    end

    assign w_val_ext = CMP_W'(r_value);
    assign w_min_ext = CMP_W'(i_freq_min);
    assign w_max_ext = CMP_W'(i_freq_max);

    // Apply the decoded key
    always_comb begin
        n_buf   = r_buf;
        n_place = r_place;
        n_key   = r_key;
        n_mode  = r_mode;
        n_freq  = r_freq;
        w_err   = 1'b0;
        case (i_evt.cls)
            CLS_DIGIT: begin
                n_key          = i_evt.code;
                n_buf[r_place] = i_evt.code;
                if (r_place != LAST_PLACE) begin
                    n_place = r_place + 1'b1;
                end
            end
            CLS_MODE: begin
                n_mode = i_evt.code[1:0];
            end
            CLS_STAR: begin
                n_key   = KEY_STAR;
                n_buf   = w_default_buf;
                n_place = '0;
            end
            CLS_HASH: begin
                n_key   = KEY_HASH;
                n_place = '0;
                if (w_val_ext >= w_min_ext && w_val_ext <= w_max_ext) begin
                    n_freq = w_val_ext[FREQ_W-1:0];
                end else begin
                    w_err = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Decimal value of the leading digits; stop at the first blank
    always_comb begin
        w_stop  = 1'b0;
        n_value = '0;
        for (int i = 0; i < ENTRY_DIGITS; i++) begin
            if (!w_stop) begin
                if (n_buf[i] > DIGIT_MAX) begin
                    w_stop = 1'b1;
                end else begin
                    n_value = VAL_W'(n_value * 10) + VAL_W'(n_buf[i]);
                end
            end
        end
    end

    // Hold state between items, advance on fire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= w_default_buf;
            r_place <= '0;
            r_key   <= DIGIT_ONE;
            r_mode  <= MODE_SINE;
            r_freq  <= FREQ_RST;
            r_value <= VAL_W'(10);
        end else if (i_fire) begin
            r_buf   <= n_buf;
            r_place <= n_place;
            r_key   <= n_key;
            r_mode  <= n_mode;
            r_freq  <= n_freq;
            r_value <= n_value;
        end
    end

    // Result: state after this item, entry value clamped to four digits
    assign w_new_ext   = CMP_W'(n_value);
    assign w_place_ext = (PLACE_W + 2)'(n_place);

    always_comb begin
        o_res.last_key     = n_key;
        o_res.wave_mode    = n_mode;
        o_res.stored_freq  = n_freq;
        o_res.entry_place  = w_place_ext[1:0];
        o_res.commit_error = w_err;
        if (w_new_ext > CMP_W'(ENTRY_SAT_MAX)) begin
            o_res.entry_value = ENTRY_SAT_MAX;
        end else begin
            o_res.entry_value = w_new_ext[FREQ_W-1:0];
        end
    end

endmodule
